// File: sv/bsa_pkg.sv
// Shared widths, codes and defaults for the bitmap slab allocator.
package bsa_pkg;

	// Field widths of the channels
	localparam int OFFSET_W = 15;
	localparam int FREED_W  = 12;
	localparam int SIZE_W   = 4;
	localparam int BYTE_W   = 8;

	// Default bucket geometry
	localparam int BUCKET_BYTES_DEF      = 8192;
	localparam int MAX_ENTRY_LOG2_DEF    = 11;
	localparam int LARGE_ENTRY_COUNT_DEF = 16;

	// Size limits and map constants
	localparam int MIN_ENTRY_LOG2   = 3;
	localparam int SMALL_LIMIT_LOG2 = 8;
	localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;

	// Command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

endpackage

// File: sv/bsa_ifs.sv
// Handshake channels of the bitmap slab allocator: request, response, size write.

interface bsa_req_if
	import bsa_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic                command;
	logic [OFFSET_W-1:0] free_offset;

	modport source (output valid, output command, output free_offset, input ready);
	modport sink   (input valid, input command, input free_offset, output ready);
endinterface

interface bsa_rsp_if
	import bsa_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic                ok;
	logic [OFFSET_W-1:0] entry_offset;
	logic [FREED_W-1:0]  freed_bytes;

	modport source (output valid, output ok, output entry_offset, output freed_bytes,
		input ready);
	modport sink   (input valid, input ok, input entry_offset, input freed_bytes,
		output ready);
endinterface

interface bsa_cfg_if
	import bsa_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] entry_size_log2;

	modport source (output valid, output entry_size_log2, input ready);
	modport sink   (input valid, input entry_size_log2, output ready);
endinterface

// File: sv/bitmap_slab_allocator.sv
// Top level of the bitmap slab allocator: occupancy map memory and its sequencer.
//
//  channel | dir | beat carries                               | accepted when
//  --------+-----+--------------------------------------------+-------------------
//  req     | in  | command, free_offset                       | req.valid & ready
//  rsp     | out | ok, entry_offset, freed_bytes              | rsp.valid & ready
//  cfg     | in  | entry_size_log2 (write clears the map)     | cfg.valid & ready
//
// Allocate walks the map memory one byte per cycle with one read in flight,
// stopping at the first byte with a clear bit or at the end of the bytes in use.
// An in-range free reads its map byte and then writes it back with the bit
// cleared; a free past the content goes straight to the response. Reset and a
// size write clear the per-byte valid flags at once; no sweep.
// A finished response waits in the output register while the next request is taken.
module bitmap_slab_allocator
	import bsa_pkg::*;
#(
	parameter int BUCKET_BYTES      = BUCKET_BYTES_DEF,
	parameter int MAX_ENTRY_LOG2    = MAX_ENTRY_LOG2_DEF,
	parameter int LARGE_ENTRY_COUNT = LARGE_ENTRY_COUNT_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	bsa_req_if.sink   req,
	bsa_rsp_if.source rsp,
	bsa_cfg_if.sink   cfg
);

	localparam int MAP_DEPTH = BUCKET_BYTES / 64;
	localparam int ADDR_W    = $clog2(MAP_DEPTH);
	localparam int NB_W      = $clog2(MAP_DEPTH + 1);
	localparam int LG_W      = $clog2(MAX_ENTRY_LOG2 + 1);
	localparam int ENT_W     = ADDR_W + 3;
	localparam int BKT_W     = $clog2(BUCKET_BYTES + 1);
	localparam int LARGE_MAP = (LARGE_ENTRY_COUNT / 8 > MAP_DEPTH) ? MAP_DEPTH
		: LARGE_ENTRY_COUNT / 8;
	localparam int CMP_W     = (OFFSET_W > NB_W + 3) ? OFFSET_W : NB_W + 3;
	localparam int SHF_W     = (ENT_W + MAX_ENTRY_LOG2 > OFFSET_W)
		? ENT_W + MAX_ENTRY_LOG2 : OFFSET_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_FRD  = 3'd2;
	localparam logic [2:0] ST_FWR  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	// Occupancy map storage
	logic [BYTE_W-1:0] map_mem [MAP_DEPTH];
	logic [MAP_DEPTH-1:0] vld_q;

	logic [2:0]          state_q;
	logic [SIZE_W-1:0]   size_q;
	logic [NB_W-1:0]     scan_q;
	logic [ADDR_W-1:0]   addr_s1;
	logic                pend_s1;
	logic [BYTE_W-1:0]   rd_data_s1;
	logic [ADDR_W-1:0]   fr_addr_q;
	logic [2:0]          fr_bit_q;
	logic                res_ok_q;
	logic [OFFSET_W-1:0] res_off_q;
	logic [FREED_W-1:0]  res_freed_q;
	logic                out_valid_q;
	logic                out_ok_q;
	logic [OFFSET_W-1:0] out_off_q;
	logic [FREED_W-1:0]  out_freed_q;

	logic [LG_W-1:0]     eff_lg;
	logic [LG_W:0]       small_shift;
	logic [BKT_W-1:0]    small_cnt;
	logic [NB_W-1:0]     nbytes;
	logic [OFFSET_W-1:0] fr_idx;
	logic                fr_in_range;
	logic [BYTE_W-1:0]   cur_byte;
	logic                cur_hit;
	logic [2:0]          cur_bit;
	logic [SHF_W-1:0]    alloc_shf;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [BYTE_W-1:0]   wr_data;
	logic                req_beat;
	logic                out_free;

	// Saturate the size register into the supported range
	always_comb begin
		if (LG_W'(size_q) < LG_W'(MIN_ENTRY_LOG2)) begin
			eff_lg = LG_W'(MIN_ENTRY_LOG2);
		end else if (LG_W'(size_q) > LG_W'(MAX_ENTRY_LOG2)) begin
			eff_lg = LG_W'(MAX_ENTRY_LOG2);
		end else begin
			eff_lg = LG_W'(size_q);
		end
	end

	// Map bytes in use for the current entry size
	assign small_shift = (LG_W + 1)'(eff_lg) + (LG_W + 1)'(3);
	assign small_cnt   = BKT_W'(BUCKET_BYTES) >> small_shift;
	assign nbytes      = (eff_lg <= LG_W'(SMALL_LIMIT_LOG2))
		? ((small_cnt > BKT_W'(MAP_DEPTH)) ? NB_W'(MAP_DEPTH) : NB_W'(small_cnt))
		: NB_W'(LARGE_MAP);

	// Free offset to entry index and range check
	assign fr_idx      = req.free_offset >> eff_lg;
	assign fr_in_range = CMP_W'(fr_idx) < (CMP_W'(nbytes) << 3);

	// Byte coming back from the map; never-written bytes read as empty
	assign cur_byte = vld_q[addr_s1] ? rd_data_s1 : '0;
	assign cur_hit  = pend_s1 && (cur_byte != FULL_BYTE);

	// Lowest clear bit of the byte under test
	always_comb begin
		cur_bit = 3'd7;
		for (int i = 7; i >= 0; i--) begin
			if (!cur_byte[i]) begin
				cur_bit = 3'(i);
			end
		end
	end

	assign alloc_shf = SHF_W'({addr_s1, cur_bit}) << eff_lg;

	assign req_beat = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	// Memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = fr_addr_q;
		wr_en   = 1'b0;
		wr_addr = fr_addr_q;
		wr_data = rd_data_s1 & ~(BYTE_W'(1) << fr_bit_q);
		case (state_q)
			ST_SCAN: begin
				if (cur_hit) begin
					wr_en   = 1'b1;
					wr_addr = addr_s1;
					wr_data = cur_byte | (BYTE_W'(1) << cur_bit);
				end else if (scan_q != nbytes) begin
					rd_en   = 1'b1;
					rd_addr = scan_q[ADDR_W-1:0];
				end
			end
			ST_FRD: begin
				rd_en = 1'b1;
			end
			ST_FWR: begin
				wr_en   = 1'b1;
				wr_data = (vld_q[fr_addr_q] ? rd_data_s1 : '0) & ~(BYTE_W'(1) << fr_bit_q);
			end
			default: begin
			end
		endcase
	end

	// Map memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= map_mem[rd_addr];
		end
	end

	// Sequencer, valid flags and size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_q  <= SIZE_W'(MIN_ENTRY_LOG2);
			vld_q   <= '0;
			scan_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				size_q <= cfg.entry_size_log2;
				vld_q  <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_beat) begin
						scan_q  <= '0;
						pend_s1 <= 1'b0;
						if (req.command == CMD_ALLOC) begin
							state_q <= ST_SCAN;
						end else if (fr_in_range) begin
							state_q <= ST_FRD;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_SCAN: begin
					if (cur_hit || scan_q == nbytes) begin
						state_q <= ST_OUT;
						pend_s1 <= 1'b0;
					end else begin
						scan_q  <= scan_q + NB_W'(1);
						pend_s1 <= 1'b1;
					end
				end
				ST_FRD: begin
					state_q <= ST_FWR;
				end
				ST_FWR: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Track the address of the read in flight
	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1 <= rd_addr;
		end
	end

	// Capture free target and build the pending result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_beat) begin
			fr_addr_q   <= fr_idx[ENT_W-1:3];
			fr_bit_q    <= fr_idx[2:0];
			res_off_q   <= '0;
			if (req.command == CMD_FREE && fr_in_range) begin
				res_ok_q    <= 1'b1;
				res_freed_q <= FREED_W'(1) << eff_lg;
			end else begin
				res_ok_q    <= 1'b0;
				res_freed_q <= '0;
			end
		end else if (state_q == ST_SCAN && cur_hit) begin
			res_ok_q  <= 1'b1;
			res_off_q <= alloc_shf[OFFSET_W-1:0];
		end
	end

	// Output register: load from pending result, drop on response beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_ok_q    <= res_ok_q;
			out_off_q   <= res_off_q;
			out_freed_q <= res_freed_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.ok           = out_ok_q;
	assign rsp.entry_offset = out_off_q;
	assign rsp.freed_bytes  = out_freed_q;

endmodule

// File: tb/sv/testbench.sv
// Testbench for the bitmap slab allocator: random request traffic checked against a bucket model.
`timescale 1ns / 1ps

module testbench;
	import bsa_pkg::*;

	localparam int MAP_DEPTH  = BUCKET_BYTES_DEF / 64;
	localparam int PHASES     = 18;
	localparam int TAIL_END   = 150;
	localparam int TAIL_PHASE = 4;

	typedef struct {
		logic                command;
		logic [OFFSET_W-1:0] free_offset;
		bit                  drain_first;
	} request_t;

	typedef struct {
		logic                ok;
		logic [OFFSET_W-1:0] entry_offset;
		logic [FREED_W-1:0]  freed_bytes;
	} reply_t;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_BURSTY} rx_mode_t;

	logic clk;
	logic arst_n;

	bsa_req_if req_ch ();
	bsa_rsp_if rsp_ch ();
	bsa_cfg_if cfg_ch ();

	bitmap_slab_allocator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Bucket model: stored size register and occupancy map
	logic [SIZE_W-1:0] size_reg;
	logic [BYTE_W-1:0] occ_map [MAP_DEPTH];

	request_t requests_todo [$];
	reply_t   replies_due [$];

	int       error_count;
	int       gap_max;
	rx_mode_t rx_mode;
	int       gap_left;
	int       burst_left;
	int       rx_cycle;
	int       stall_left;

	logic [SIZE_W-1:0] size_plan [PHASES];

	// Clamp the stored size register into the supported range
	function automatic int eff_log2(input logic [SIZE_W-1:0] v);
		if (v < MIN_ENTRY_LOG2)
			return MIN_ENTRY_LOG2;
		if (v > MAX_ENTRY_LOG2_DEF)
			return MAX_ENTRY_LOG2_DEF;
		return int'(v);
	endfunction

	// Number of map bytes in use at a given entry size
	function automatic int map_bytes(input int lg);
		int count;
		if (lg <= SMALL_LIMIT_LOG2)
			count = BUCKET_BYTES_DEF >> lg;
		else
			count = LARGE_ENTRY_COUNT_DEF;
		count = count >> 3;
		if (count > MAP_DEPTH)
			count = MAP_DEPTH;
		return count;
	endfunction

	// Apply one request to the bucket model and return the reply it yields
	function automatic reply_t bucket_reply(input logic cmd, input logic [OFFSET_W-1:0] offs);
		reply_t r;
		int     lg;
		int     nbytes;
		int     i;
		int     bitn;
		int     idx;
		r.ok = 1'b0;
		r.entry_offset = '0;
		r.freed_bytes = '0;
		lg = eff_log2(size_reg);
		nbytes = map_bytes(lg);
		if (cmd == CMD_ALLOC) begin
			for (i = 0; i < nbytes; i++) begin
				if (occ_map[i] != FULL_BYTE) begin
					bitn = 0;
					while (bitn < 7 && occ_map[i][bitn])
						bitn++;
					occ_map[i][bitn] = 1'b1;
					r.ok = 1'b1;
					r.entry_offset = OFFSET_W'(((i * 8) + bitn) << lg);
					break;
				end
			end
		end else begin
			idx = int'(offs) >> lg;
			if (idx < nbytes * 8) begin
				occ_map[idx >> 3][idx & 7] = 1'b0;
				r.ok = 1'b1;
				r.freed_bytes = FREED_W'(1 << lg);
			end
		end
		return r;
	endfunction

	function automatic void push_req(input logic cmd, input int offs, input bit drain);
		request_t it;
		it.command = cmd;
		it.free_offset = OFFSET_W'(offs);
		it.drain_first = drain;
		requests_todo.push_back(it);
	endfunction

	// Queue one phase of traffic: optional fill to full, then a mix of allocs and frees
	task automatic queue_phase(input int n_items, input int alloc_pct);
		int lg;
		int entries;
		int live;
		int k;
		int idx;
		int offs;
		bit fill;
		bit drain;
		lg = eff_log2(size_reg);
		entries = map_bytes(lg) * 8;
		fill = (entries + 20 <= n_items);
		live = 0;
		for (k = 0; k < n_items; k++) begin
			drain = (k == n_items / 2) || ($urandom_range(0, 99) == 0);
			if ((fill && k < entries + 2) || $urandom_range(0, 99) < alloc_pct) begin
				push_req(CMD_ALLOC, $urandom, drain);
				if (live < entries)
					live++;
			end else begin
				idx = $urandom_range(0, (live < entries) ? live : entries - 1);
				case ($urandom_range(0, 9))
					0: offs = $urandom;
					1: offs = (entries << lg) + $urandom_range(0, 255);
					2: offs = (idx << lg) | ($urandom & ((1 << lg) - 1));
					default: offs = idx << lg;
				endcase
				push_req(CMD_FREE, offs, drain);
				if (live > 0 && idx < live)
					live--;
			end
		end
	endtask

	// Hold until no beat is pending, in flight or outstanding
	task automatic wait_idle(input int tail);
		do
			@(posedge clk);
		while (requests_todo.size() != 0 || req_ch.valid || replies_due.size() != 0);
		repeat (tail) @(posedge clk);
	endtask

	// Write the entry size register; a write clears the map
	task automatic write_size(input logic [SIZE_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.entry_size_log2 <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		size_reg = v;
		foreach (occ_map[j])
			occ_map[j] = '0;
	endtask

	// Clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Request driver: bursts with random gaps, optional drain before an item
	always @(posedge clk) begin : tx_side
		request_t nxt;
		bit       load;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.command <= CMD_ALLOC;
			req_ch.free_offset <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				replies_due.push_back(bucket_reply(req_ch.command, req_ch.free_offset));
			if (!req_ch.valid || req_ch.ready) begin
				load = 1'b0;
				if (gap_left > 0)
					gap_left--;
				else if (requests_todo.size() != 0 &&
						!(requests_todo[0].drain_first && replies_due.size() != 0))
					load = 1'b1;
				if (load) begin
					nxt = requests_todo.pop_front();
					req_ch.command <= nxt.command;
					req_ch.free_offset <= nxt.free_offset;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
					end
				end
				req_ch.valid <= load;
			end
		end
	end

	// Response monitor: check each beat against the oldest reply due, then pick ready
	always @(posedge clk) begin : rx_side
		reply_t due;
		bit     rdy;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (replies_due.size() == 0) begin
					$error("response beat with no reply due");
					error_count++;
				end else begin
					due = replies_due.pop_front();
					if (rsp_ch.ok !== due.ok) begin
						$error("ok: expected %0d, got %0d", due.ok, rsp_ch.ok);
						error_count++;
					end
					if (rsp_ch.entry_offset !== due.entry_offset) begin
						$error("entry_offset: expected %0d, got %0d",
							due.entry_offset, rsp_ch.entry_offset);
						error_count++;
					end
					if (rsp_ch.freed_bytes !== due.freed_bytes) begin
						$error("freed_bytes: expected %0d, got %0d",
							due.freed_bytes, rsp_ch.freed_bytes);
						error_count++;
					end
				end
			end
			rx_cycle++;
			case (rx_mode)
				RX_ALWAYS: rdy = 1'b1;
				RX_RANDOM: rdy = ($urandom_range(0, 3) != 0);
				RX_PATTERN: rdy = ((rx_cycle % 7) < 4);
				default: begin
					if (stall_left > 0)
						stall_left--;
					else if ($urandom_range(0, 9) == 0)
						stall_left = $urandom_range(1, 20);
					rdy = (stall_left == 0);
				end
			endcase
			rsp_ch.ready <= rdy;
		end
	end

	// Stimulus and end of run
	initial begin
		int p;
		int lg;
		int k;
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_ALLOC;
		req_ch.free_offset = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.entry_size_log2 = '0;
		size_reg = SIZE_W'(MIN_ENTRY_LOG2);
		foreach (occ_map[j])
			occ_map[j] = '0;
		error_count = 0;
		gap_max = 0;
		rx_mode = RX_ALWAYS;
		gap_left = 0;
		burst_left = 0;
		rx_cycle = 0;
		stall_left = 0;
		size_plan = '{4'd8, 4'd3, 4'd11, 4'd4, 4'd6, 4'd5, 4'd7, 4'd9, 4'd10,
			4'd0, 4'd15, 4'd12, 4'd6, 4'd2, 4'd1, 4'd14, 4'd8, 4'd11};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset size: first-fit, unaligned free, double free, offsets past the content
		push_req(CMD_ALLOC, 0, 1'b0);
		push_req(CMD_ALLOC, 0, 1'b0);
		push_req(CMD_FREE, 9, 1'b0);
		push_req(CMD_FREE, 9, 1'b0);
		push_req(CMD_FREE, 16'h7FFF, 1'b0);
		push_req(CMD_FREE, BUCKET_BYTES_DEF, 1'b0);
		push_req(CMD_ALLOC, 16'h7FFF, 1'b0);
		wait_idle(TAIL_PHASE);

		// Oversized register value saturates to the largest entry; fill past full
		write_size(4'd15);
		for (k = 0; k < 17; k++)
			push_req(CMD_ALLOC, 0, 1'b0);
		push_req(CMD_FREE, 16'h7FFF, 1'b0);
		push_req(CMD_ALLOC, 0, 1'b0);
		wait_idle(TAIL_PHASE);

		// Random phases across the size range with varied idling on both sides
		for (p = 0; p < PHASES; p++) begin
			write_size(size_plan[p]);
			gap_max <= (p % 4 == 0) ? 0 : (p % 4 == 1) ? 3 : (p % 4 == 2) ? 8 : 20;
			rx_mode <= rx_mode_t'((p / 2) % 4);
			lg = eff_log2(size_plan[p]);
			if (lg == MIN_ENTRY_LOG2)
				queue_phase(160, 85);
			else
				queue_phase(95, 55 + (p % 3) * 10);
			wait_idle(TAIL_PHASE);
		end

		wait_idle(TAIL_END);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
sv/bsa_pkg.sv
sv/bsa_ifs.sv
sv/bitmap_slab_allocator.sv
tb/sv/testbench.sv
